[rtl/wfs_pkg.sv]
// Shared types and constants for the first-step wave stencil.
// No dependencies; imported by every module of the block except wfs_ram.
`timescale 1ns / 1ps
`default_nettype none

package wfs_pkg;

  localparam int GRID_COLS_W = 11;
  localparam int GRID_ROWS_W = 16;
  localparam int COEF_W      = 32;
  localparam int COEF_HALF_W = 16;
  localparam int COEF_TAIL   = 8;
  localparam int VALUE_W     = 32;
  localparam int ROW_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLS = 2'd0,
    CFG_GRID_ROWS = 2'd1,
    CFG_COEF_X    = 2'd2,
    CFG_COEF_Y    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic run_last;
    logic frame_done;
  } wfs_flags_t;

endpackage

`default_nettype wire

[rtl/wave_first_step_stencil_core.sv]
// Top level of the first-step wave stencil: configuration registers and wiring.
// Depends on wfs_pkg, wfs_front, wfs_arith (and wfs_ram through wfs_front).
//
//   channel | ports                                            | direction
//   --------+--------------------------------------------------+----------
//   input   | in_valid, in_stall, in_sample                    | in
//   result  | out_valid, out_stall, out_value, out_row,        | out
//           | out_col, out_run_last, out_frame_done            |
//   config  | cfg_we, cfg_index, cfg_wdata                     | in
//
// One input per cycle while each causes at most one result and the result
// channel does not stall; one that causes several results (row and frame
// ends, up to four) holds the input until the single result slot sequencer
// has issued them. A result passes the s1, p1, p2 and output registers.
// Reset clears position counters and pipeline valids; no clearing pass.
// A stall on the result channel fills the pipeline, then stalls the input.
`timescale 1ns / 1ps
`default_nettype none

module wave_first_step_stencil_core #(
  parameter int MAX_COLS     = 1024,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [wfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [wfs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0]     in_sample,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [wfs_pkg::VALUE_W-1:0]      out_value,
  output logic [wfs_pkg::ROW_W-1:0]               out_row,
  output logic [$clog2(MAX_COLS)-1:0]             out_col,
  output logic                                    out_run_last,
  output logic                                    out_frame_done
);

  import wfs_pkg::*;

  localparam int COL_W = $clog2(MAX_COLS);

  logic [GRID_COLS_W-1:0] grid_cols_r;
  logic [GRID_ROWS_W-1:0] grid_rows_r;
  logic [COEF_W-1:0]      coef_x_r;
  logic [COEF_W-1:0]      coef_y_r;
  logic                   pos_clear;

  logic                    op_valid;
  logic                    op_ready;
  logic signed [SAMPLE_WIDTH-1:0] op_center, op_left, op_right, op_below, op_above;
  logic [ROW_W-1:0]        op_row;
  logic [COL_W-1:0]        op_col;
  wfs_flags_t              op_flags;
  wfs_flags_t              out_flags;

  assign pos_clear = cfg_we && (cfg_idx_t'(cfg_index) == CFG_GRID_COLS ||
                                cfg_idx_t'(cfg_index) == CFG_GRID_ROWS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= GRID_COLS_W'(1024);
      grid_rows_r <= GRID_ROWS_W'(1024);
      coef_x_r    <= '0;
      coef_y_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GRID_COLS: grid_cols_r <= cfg_wdata[GRID_COLS_W-1:0];
        CFG_GRID_ROWS: grid_rows_r <= cfg_wdata[GRID_ROWS_W-1:0];
        CFG_COEF_X:    coef_x_r    <= cfg_wdata[COEF_W-1:0];
        CFG_COEF_Y:    coef_y_r    <= cfg_wdata[COEF_W-1:0];
      endcase
    end
  end

  wfs_front #(
    .MAX_COLS     (MAX_COLS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .grid_cols (grid_cols_r),
    .grid_rows (grid_rows_r),
    .pos_clear (pos_clear),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op_center (op_center),
    .op_left   (op_left),
    .op_right  (op_right),
    .op_below  (op_below),
    .op_above  (op_above),
    .op_row    (op_row),
    .op_col    (op_col),
    .op_flags  (op_flags)
  );

  wfs_arith #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COL_W        (COL_W)
  ) u_arith (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef_x    (coef_x_r),
    .coef_y    (coef_y_r),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op_center (op_center),
    .op_left   (op_left),
    .op_right  (op_right),
    .op_below  (op_below),
    .op_above  (op_above),
    .op_row    (op_row),
    .op_col    (op_col),
    .op_flags  (op_flags),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_flags (out_flags)
  );

  assign out_run_last   = out_flags.run_last;
  assign out_frame_done = out_flags.frame_done;

endmodule

`default_nettype wire

[rtl/wfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the two line buffers.
`timescale 1ns / 1ps
`default_nettype none

module wfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/wfs_front.sv]
// Raster position tracking, line buffers, 3x2 window and result slot sequencer.
// Depends on wfs_pkg and wfs_ram.
`timescale 1ns / 1ps
`default_nettype none

module wfs_front #(
  parameter int MAX_COLS     = 1024,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [wfs_pkg::GRID_COLS_W-1:0]      grid_cols,
  input  wire logic [wfs_pkg::GRID_ROWS_W-1:0]      grid_rows,
  input  wire logic                                 pos_clear,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       in_sample,
  output logic                                      op_valid,
  input  wire logic                                 op_ready,
  output logic signed [SAMPLE_WIDTH-1:0]            op_center,
  output logic signed [SAMPLE_WIDTH-1:0]            op_left,
  output logic signed [SAMPLE_WIDTH-1:0]            op_right,
  output logic signed [SAMPLE_WIDTH-1:0]            op_below,
  output logic signed [SAMPLE_WIDTH-1:0]            op_above,
  output logic [wfs_pkg::ROW_W-1:0]                 op_row,
  output logic [$clog2(MAX_COLS)-1:0]               op_col,
  output wfs_pkg::wfs_flags_t                       op_flags
);

  import wfs_pkg::*;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CNT_W = $clog2(MAX_COLS + 1);
  localparam int EXT_W = (CNT_W > GRID_COLS_W) ? CNT_W : GRID_COLS_W;
  localparam int SW    = SAMPLE_WIDTH;

  typedef enum logic [1:0] {
    SLOT_UL = 2'd0,
    SLOT_UR = 2'd1,
    SLOT_LL = 2'd2,
    SLOT_LR = 2'd3
  } slot_t;

  logic [ROW_W-1:0] row_cnt_r;
  logic [COL_W-1:0] col_cnt_r;
  logic [ROW_W-1:0] row_nxt;
  logic [COL_W-1:0] col_nxt;

  logic [EXT_W-1:0] gcols_ext;
  logic [EXT_W-1:0] cols_eff;
  logic [ROW_W-1:0] rows_eff;
  logic [ROW_W-1:0] r_pos;
  logic [COL_W-1:0] c_pos;
  logic [EXT_W-1:0] c_ext;
  logic             last_col;
  logic             last_row;
  logic [3:0]       new_mask;
  logic             accept;

  logic                 s1_valid_r;
  logic [3:0]           s1_mask_r;
  logic signed [SW-1:0] s1_sample_r;
  logic [ROW_W-1:0]     s1_row_r;
  logic [COL_W-1:0]     s1_col_r;
  logic                 s1_c1_r;
  logic                 s1_r1_r;

  logic signed [SW-1:0] w00_r, w01_r, w10_r, w11_r, w20_r, w21_r;
  logic signed [SW-1:0] older_q;
  logic signed [SW-1:0] newer_q;

  slot_t      slot;
  logic [3:0] rest;
  logic       fire;
  logic       done;

  // grid size: columns clamped to what the buffers support, both at least 2
  always_comb begin
    gcols_ext = EXT_W'(grid_cols);
    if (gcols_ext < EXT_W'(2)) begin
      cols_eff = EXT_W'(2);
    end else if (gcols_ext > EXT_W'(MAX_COLS)) begin
      cols_eff = EXT_W'(MAX_COLS);
    end else begin
      cols_eff = gcols_ext;
    end
    rows_eff = (grid_rows < ROW_W'(2)) ? ROW_W'(2) : grid_rows;
  end

  always_comb begin
    if (row_cnt_r >= rows_eff || EXT_W'(col_cnt_r) >= cols_eff) begin
      r_pos = '0;
      c_pos = '0;
    end else begin
      r_pos = row_cnt_r;
      c_pos = col_cnt_r;
    end
    c_ext    = EXT_W'(c_pos);
    last_col = (c_ext == cols_eff - EXT_W'(1));
    last_row = (r_pos == rows_eff - ROW_W'(1));

    new_mask          = '0;
    new_mask[SLOT_UL] = (r_pos != '0) && (c_pos != '0);
    new_mask[SLOT_UR] = (r_pos != '0) && last_col;
    new_mask[SLOT_LL] = last_row && (c_pos != '0);
    new_mask[SLOT_LR] = last_row && last_col;

    if (c_ext + EXT_W'(1) >= cols_eff) begin
      col_nxt = '0;
      if ((ROW_W + 1)'(r_pos) + (ROW_W + 1)'(1) >= (ROW_W + 1)'(rows_eff)) begin
        row_nxt = '0;
      end else begin
        row_nxt = r_pos + ROW_W'(1);
      end
    end else begin
      col_nxt = c_pos + COL_W'(1);
      row_nxt = r_pos;
    end
  end

  // pick the next pending result of the held transaction
  always_comb begin
    if (s1_mask_r[SLOT_UL]) begin
      slot = SLOT_UL;
    end else if (s1_mask_r[SLOT_UR]) begin
      slot = SLOT_UR;
    end else if (s1_mask_r[SLOT_LL]) begin
      slot = SLOT_LL;
    end else begin
      slot = SLOT_LR;
    end
    rest       = s1_mask_r;
    rest[slot] = 1'b0;
  end

  assign op_valid = s1_valid_r && (s1_mask_r != '0);
  assign fire     = op_valid && op_ready;
  assign done     = s1_valid_r && ((s1_mask_r == '0) || (fire && rest == '0));
  assign in_stall = s1_valid_r && !done;
  assign accept   = in_valid && !in_stall;

  assign op_flags.run_last   = (rest == '0);
  assign op_flags.frame_done = (slot == SLOT_LR);

  always_comb begin
    unique case (slot)
      SLOT_UL: begin
        op_row    = s1_row_r - ROW_W'(1);
        op_col    = s1_col_r - COL_W'(1);
        op_center = w10_r;
        op_left   = s1_c1_r ? newer_q : w11_r;
        op_right  = newer_q;
        op_below  = s1_r1_r ? w20_r : w00_r;
        op_above  = w20_r;
      end
      SLOT_UR: begin
        op_row    = s1_row_r - ROW_W'(1);
        op_col    = s1_col_r;
        op_center = newer_q;
        op_left   = w10_r;
        op_right  = w10_r;
        op_below  = s1_r1_r ? s1_sample_r : older_q;
        op_above  = s1_sample_r;
      end
      SLOT_LL: begin
        op_row    = s1_row_r;
        op_col    = s1_col_r - COL_W'(1);
        op_center = w20_r;
        op_left   = s1_c1_r ? s1_sample_r : w21_r;
        op_right  = s1_sample_r;
        op_below  = w10_r;
        op_above  = w10_r;
      end
      SLOT_LR: begin
        op_row    = s1_row_r;
        op_col    = s1_col_r;
        op_center = s1_sample_r;
        op_left   = w20_r;
        op_right  = w20_r;
        op_below  = newer_q;
        op_above  = newer_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r  <= '0;
      col_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
      s1_mask_r  <= '0;
    end else begin
      if (pos_clear) begin
        row_cnt_r <= '0;
        col_cnt_r <= '0;
      end else if (accept) begin
        row_cnt_r <= row_nxt;
        col_cnt_r <= col_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
        s1_mask_r  <= new_mask;
      end else if (done) begin
        s1_valid_r <= 1'b0;
        s1_mask_r  <= '0;
      end else if (fire) begin
        s1_mask_r <= rest;
      end
    end
  end

  // hold the transaction payload; advance the window when it retires
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r <= in_sample;
      s1_row_r    <= r_pos;
      s1_col_r    <= c_pos;
      s1_c1_r     <= (c_pos == COL_W'(1));
      s1_r1_r     <= (r_pos == ROW_W'(1));
    end
    if (done) begin
      w01_r <= w00_r;
      w00_r <= older_q;
      w11_r <= w10_r;
      w10_r <= newer_q;
      w21_r <= w20_r;
      w20_r <= s1_sample_r;
    end
  end

  wfs_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_COLS)
  ) u_line_older (
    .clk   (clk),
    .we    (done),
    .waddr (s1_col_r),
    .wdata (newer_q),
    .re    (accept),
    .raddr (c_pos),
    .rdata (older_q)
  );

  wfs_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_COLS)
  ) u_line_newer (
    .clk   (clk),
    .we    (done),
    .waddr (s1_col_r),
    .wdata (s1_sample_r),
    .re    (accept),
    .raddr (c_pos),
    .rdata (newer_q)
  );

endmodule

`default_nettype wire

[rtl/wfs_arith.sv]
// Laplacian terms, Q8.24 weighting, saturating sum and output register.
// Depends on wfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wfs_arith #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int COL_W        = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [wfs_pkg::COEF_W-1:0]        coef_x,
  input  wire logic [wfs_pkg::COEF_W-1:0]        coef_y,
  input  wire logic                              op_valid,
  output logic                                   op_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    op_center,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    op_left,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    op_right,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    op_below,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    op_above,
  input  wire logic [wfs_pkg::ROW_W-1:0]         op_row,
  input  wire logic [COL_W-1:0]                  op_col,
  input  wire wfs_pkg::wfs_flags_t               op_flags,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [wfs_pkg::VALUE_W-1:0]     out_value,
  output logic [wfs_pkg::ROW_W-1:0]              out_row,
  output logic [COL_W-1:0]                       out_col,
  output wfs_pkg::wfs_flags_t                    out_flags
);

  import wfs_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int LAP_W = SW + 2;
  localparam int PRD_W = LAP_W + COEF_HALF_W + 1;
  localparam int MID_W = PRD_W + 1;
  localparam int SUM_W = (SW + 14 > VALUE_W + 1) ? SW + 14 : VALUE_W + 1;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W - VALUE_W + 1){1'b0}}, {(VALUE_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W - VALUE_W + 1){1'b1}}, {(VALUE_W - 1){1'b0}}};

  logic signed [LAP_W-1:0] lapx;
  logic signed [LAP_W-1:0] lapy;

  logic                    p1_valid_r;
  logic signed [SW-1:0]    p1_center_r;
  logic signed [LAP_W-1:0] p1_lapx_r;
  logic signed [LAP_W-1:0] p1_lapy_r;
  logic [ROW_W-1:0]        p1_row_r;
  logic [COL_W-1:0]        p1_col_r;
  wfs_flags_t              p1_flags_r;

  logic signed [COEF_HALF_W:0] cxh, cxl, cyh, cyl;

  logic                    p2_valid_r;
  logic signed [SW-1:0]    p2_center_r;
  logic signed [PRD_W-1:0] p2_hix_r, p2_lox_r, p2_hiy_r, p2_loy_r;
  logic [ROW_W-1:0]        p2_row_r;
  logic [COL_W-1:0]        p2_col_r;
  wfs_flags_t              p2_flags_r;

  logic signed [PRD_W-1:0] lox_sh, loy_sh;
  logic signed [MID_W-1:0] tx, ty, wx, wy;
  logic signed [SUM_W-1:0] sum;
  logic signed [VALUE_W-1:0] value_sat;

  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic [ROW_W-1:0]          out_row_r;
  logic [COL_W-1:0]          out_col_r;
  wfs_flags_t                out_flags_r;

  logic out_ready;
  logic p2_ready;
  logic p1_ready;

  assign out_ready = !out_valid_r || !out_stall;
  assign p2_ready  = !p2_valid_r || out_ready;
  assign p1_ready  = !p1_valid_r || p2_ready;
  assign op_ready  = p1_ready;

  // exact second differences
  assign lapx = {{2{op_left[SW-1]}}, op_left} + {{2{op_right[SW-1]}}, op_right}
              - {op_center[SW-1], op_center, 1'b0};
  assign lapy = {{2{op_below[SW-1]}}, op_below} + {{2{op_above[SW-1]}}, op_above}
              - {op_center[SW-1], op_center, 1'b0};

  assign cxh = {1'b0, coef_x[COEF_W-1:COEF_HALF_W]};
  assign cxl = {1'b0, coef_x[COEF_HALF_W-1:0]};
  assign cyh = {1'b0, coef_y[COEF_W-1:COEF_HALF_W]};
  assign cyl = {1'b0, coef_y[COEF_HALF_W-1:0]};

  // floor((hi + floor(lo / 2^16)) / 2^8), then saturate the total
  always_comb begin
    lox_sh = p2_lox_r >>> COEF_HALF_W;
    loy_sh = p2_loy_r >>> COEF_HALF_W;
    tx     = MID_W'(p2_hix_r) + MID_W'(lox_sh);
    ty     = MID_W'(p2_hiy_r) + MID_W'(loy_sh);
    wx     = tx >>> COEF_TAIL;
    wy     = ty >>> COEF_TAIL;
    sum    = SUM_W'(p2_center_r) + SUM_W'(wx) + SUM_W'(wy);
    if (sum > SAT_HI) begin
      value_sat = SAT_HI[VALUE_W-1:0];
    end else if (sum < SAT_LO) begin
      value_sat = SAT_LO[VALUE_W-1:0];
    end else begin
      value_sat = sum[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (p1_ready) begin
        p1_valid_r <= op_valid;
      end
      if (p2_ready) begin
        p2_valid_r <= p1_valid_r;
      end
      if (out_ready) begin
        out_valid_r <= p2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p1_ready && op_valid) begin
      p1_center_r <= op_center;
      p1_lapx_r   <= lapx;
      p1_lapy_r   <= lapy;
      p1_row_r    <= op_row;
      p1_col_r    <= op_col;
      p1_flags_r  <= op_flags;
    end
    if (p2_ready && p1_valid_r) begin
      p2_center_r <= p1_center_r;
      p2_hix_r    <= p1_lapx_r * cxh;
      p2_lox_r    <= p1_lapx_r * cxl;
      p2_hiy_r    <= p1_lapy_r * cyh;
      p2_loy_r    <= p1_lapy_r * cyl;
      p2_row_r    <= p1_row_r;
      p2_col_r    <= p1_col_r;
      p2_flags_r  <= p1_flags_r;
    end
    if (out_ready && p2_valid_r) begin
      out_value_r <= value_sat;
      out_row_r   <= p2_row_r;
      out_col_r   <= p2_col_r;
      out_flags_r <= p2_flags_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_flags = out_flags_r;

endmodule

`default_nettype wire

[test/stencil_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the wave stencil core: mirrors its registers, line buffers and window,
// predicts each result from the accepted samples and compares results in order.
// Depends on wfs_pkg.

module stencil_checker #(
  parameter int MAX_COLS = 1024,
  parameter int COL_W    = $clog2(MAX_COLS)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [wfs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [wfs_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic signed [wfs_pkg::VALUE_W-1:0]    in_sample,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [wfs_pkg::VALUE_W-1:0]    out_value,
  input  logic [wfs_pkg::ROW_W-1:0]             out_row,
  input  logic [COL_W-1:0]                      out_col,
  input  logic                                  out_run_last,
  input  logic                                  out_frame_done,
  output int                                    mismatches,
  output int                                    outstanding
);
  import wfs_pkg::*;

  localparam logic signed [71:0] SAT_HI = 72'sd2147483647;
  localparam logic signed [71:0] SAT_LO = -72'sd2147483648;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic                      run_last;
    logic                      frame_done;
  } stencil_result_t;

  logic [GRID_COLS_W-1:0]    grid_cols;
  logic [GRID_ROWS_W-1:0]    grid_rows;
  logic [COEF_W-1:0]         coef_x;
  logic [COEF_W-1:0]         coef_y;
  logic signed [VALUE_W-1:0] line_older [MAX_COLS];
  logic signed [VALUE_W-1:0] line_newer [MAX_COLS];
  logic signed [VALUE_W-1:0] win [3][2];
  int unsigned               row_pos;
  int unsigned               col_pos;
  stencil_result_t           values_due [$];

  // floor(lap * coef / 2^24), coef unsigned Q8.24
  function automatic logic signed [71:0] weigh(input logic signed [71:0] lap,
                                               input logic [COEF_W-1:0] coef);
    logic signed [71:0] k;
    k = $signed({40'd0, coef});
    return (lap * k) >>> 24;
  endfunction

  function automatic stencil_result_t stencil_point(
    input int unsigned r, c,
    input logic signed [VALUE_W-1:0] ctr, lf, rt, bl, ab
  );
    logic signed [71:0] ce, le, re, be, ae, acc;
    stencil_result_t p;
    ce = ctr;
    le = lf;
    re = rt;
    be = bl;
    ae = ab;
    acc = ce + weigh(le - 2 * ce + re, coef_x) + weigh(be - 2 * ce + ae, coef_y);
    if (acc > SAT_HI) begin
      acc = SAT_HI;
    end else if (acc < SAT_LO) begin
      acc = SAT_LO;
    end
    p.value      = acc[VALUE_W-1:0];
    p.row        = r[ROW_W-1:0];
    p.col        = c[COL_W-1:0];
    p.run_last   = 1'b0;
    p.frame_done = 1'b0;
    return p;
  endfunction

  task automatic check_field(input string what, input longint want, input longint seen);
    if (want != seen) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    int unsigned               ncols, nrows, r, c, ci, n, i;
    logic signed [VALUE_W-1:0] s, older, newer, lf, bl;
    logic                      at_last_col, at_last_row;
    stencil_result_t           batch [4];
    stencil_result_t           want;
    if (!rst_n) begin
      grid_cols = 11'd1024;
      grid_rows = 16'd1024;
      coef_x = '0;
      coef_y = '0;
      for (i = 0; i < MAX_COLS; i++) begin
        line_older[i] = '0;
        line_newer[i] = '0;
      end
      for (i = 0; i < 3; i++) begin
        win[i][0] = '0;
        win[i][1] = '0;
      end
      row_pos = 0;
      col_pos = 0;
      values_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_GRID_COLS: begin
            grid_cols = cfg_wdata[GRID_COLS_W-1:0];
            row_pos = 0;
            col_pos = 0;
          end
          CFG_GRID_ROWS: begin
            grid_rows = cfg_wdata[GRID_ROWS_W-1:0];
            row_pos = 0;
            col_pos = 0;
          end
          CFG_COEF_X: coef_x = cfg_wdata[COEF_W-1:0];
          CFG_COEF_Y: coef_y = cfg_wdata[COEF_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        s = in_sample;
        ncols = (grid_cols < 2) ? 2 : ((grid_cols > MAX_COLS) ? MAX_COLS : grid_cols);
        nrows = (grid_rows < 2) ? 2 : grid_rows;
        r = row_pos;
        c = col_pos;
        n = 0;
        if (r >= nrows || c >= ncols) begin
          r = 0;
          c = 0;
        end
        ci = c % MAX_COLS;
        older = line_older[ci];
        newer = line_newer[ci];
        at_last_col = (c == ncols - 1);
        at_last_row = (r == nrows - 1);

        if (r >= 1 && c >= 1) begin
          lf = (c == 1) ? newer : win[1][1];
          bl = (r == 1) ? win[2][0] : win[0][0];
          batch[n] = stencil_point(r - 1, c - 1, win[1][0], lf, newer, bl, win[2][0]);
          n++;
        end
        if (r >= 1 && at_last_col) begin
          bl = (r == 1) ? s : older;
          batch[n] = stencil_point(r - 1, c, newer, win[1][0], win[1][0], bl, s);
          n++;
        end
        if (at_last_row && c >= 1) begin
          lf = (c == 1) ? s : win[2][1];
          batch[n] = stencil_point(r, c - 1, win[2][0], lf, s, win[1][0], win[1][0]);
          n++;
        end
        if (at_last_row && at_last_col) begin
          batch[n] = stencil_point(r, c, s, win[2][0], win[2][0], newer, newer);
          batch[n].frame_done = 1'b1;
          n++;
        end
        for (i = 0; i < n; i++) begin
          if (i == n - 1) begin
            batch[i].run_last = 1'b1;
          end
          values_due.push_back(batch[i]);
        end

        line_older[ci] = newer;
        line_newer[ci] = s;
        win[0][1] = win[0][0];
        win[0][0] = older;
        win[1][1] = win[1][0];
        win[1][0] = newer;
        win[2][1] = win[2][0];
        win[2][0] = s;

        c++;
        if (c >= ncols) begin
          c = 0;
          r++;
          if (r >= nrows) begin
            r = 0;
          end
        end
        row_pos = r;
        col_pos = c;
      end

      if (out_valid && !out_stall) begin
        if (values_due.size() == 0) begin
          $display("%0t: result with none expected: value %0d row %0d col %0d",
                   $time, out_value, out_row, out_col);
          mismatches++;
        end else begin
          want = values_due.pop_front();
          check_field("value", $signed(want.value), out_value);
          check_field("row", want.row, out_row);
          check_field("col", want.col, out_col);
          check_field("run_last", want.run_last, out_run_last);
          check_field("frame_done", want.frame_done, out_frame_done);
        end
      end
    end
    outstanding <= values_due.size();
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Testbench top for wave_first_step_stencil_core: clock, reset, configuration phases,
// sample stimulus with random idling and the verdict. Depends on wfs_pkg and stencil_checker.

module tb;
  import wfs_pkg::*;

  localparam int          MAX_COLS     = 1024;
  localparam int          COL_W        = $clog2(MAX_COLS);
  localparam int unsigned RANDOM_ITEMS = 320;
  localparam int unsigned CALM_AFTER   = 260;
  localparam int unsigned LONG_HOLD    = 250;
  localparam int unsigned TAIL_CYCLES  = 32;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = CFG_GRID_COLS;
  logic [CFG_DATA_W-1:0]     cfg_wdata = '0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic signed [VALUE_W-1:0] in_sample = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] out_value;
  logic [ROW_W-1:0]          out_row;
  logic [COL_W-1:0]          out_col;
  logic                      out_run_last;
  logic                      out_frame_done;
  int                        mismatches;
  int                        outstanding;
  int unsigned               cycles    = 0;
  bit                        calm      = 1'b0;
  bit                        hold_req  = 1'b0;
  logic [31:0]               fixed_samples [$];

  always #5 clk = ~clk;

  wave_first_step_stencil_core #(
    .MAX_COLS    (MAX_COLS),
    .SAMPLE_WIDTH(VALUE_W)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_run_last  (out_run_last),
    .out_frame_done(out_frame_done)
  );

  stencil_checker #(
    .MAX_COLS(MAX_COLS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_run_last  (out_run_last),
    .out_frame_done(out_frame_done),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom_range(0, 32'h0040_0000);
      default: return $urandom();
    endcase
  endfunction

  // Program the grid and weights, offer count transactions, then drain everything in flight.
  task automatic run_phase(input logic [CFG_DATA_W-1:0] cols, rows, cx, cy,
                           input int unsigned count);
    logic [31:0] s;
    cfg_we <= 1'b1;
    cfg_index <= CFG_GRID_COLS;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_index <= CFG_GRID_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_index <= CFG_COEF_X;
    cfg_wdata <= cx;
    @(posedge clk);
    cfg_index <= CFG_COEF_Y;
    cfg_wdata <= cy;
    @(posedge clk);
    cfg_we <= 1'b0;

    repeat (count) begin
      if (fixed_samples.size() != 0) begin
        s = fixed_samples.pop_front();
      end else begin
        case ($urandom_range(0, 9))
          0:       s = 32'h7FFF_FFFF;
          1:       s = 32'h8000_0000;
          2, 3, 4: s = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
          default: s = $urandom();
        endcase
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_sample <= s;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin : receiver
    bit held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat (calm ? 1 : $urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("wave_first_step_stencil_core: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned random_sent, cols, rows, ncols, nrows, frame, span, count;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // undersized grid acts as 2x2, full weights, saturating extremes, frame wrap
    fixed_samples = {32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000};
    run_phase(0, 1, '1, '1, 8);
    fixed_samples = {32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h1234_5678,
                     32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0002_0000,
                     32'hAAAA_AAAA};
    run_phase(3, 3, '0, 32'h0100_0000, 9);
    // tall grid left part-way, so the next size write restarts the position
    fixed_samples = {32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                     32'h5A5A_5A5A, 32'hA5A5_A5A5};
    run_phase(2, 65535, 32'h0080_0000, 32'h0000_0001, 6);

    // oversized width clamps to the full line buffer
    run_phase(2047, 2, pick_weight(), pick_weight(), 20);

    hold_req = 1'b1;
    run_phase(5, 12, pick_weight(), pick_weight(), 60);
    random_sent = 60;

    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent >= CALM_AFTER) begin
        calm = 1'b1;
      end
      case ($urandom_range(0, 9))
        0:       cols = $urandom_range(0, 1);
        1, 2:    cols = $urandom_range(9, 40);
        default: cols = $urandom_range(2, 8);
      endcase
      case ($urandom_range(0, 9))
        0:       rows = $urandom_range(0, 1);
        1:       rows = 65535;
        default: rows = $urandom_range(2, 6);
      endcase
      ncols = (cols < 2) ? 2 : cols;
      nrows = (rows < 2) ? 2 : rows;
      frame = ncols * nrows;
      span = (frame > 120) ? 120 : frame;
      if (frame > 120 || $urandom_range(0, 4) == 0) begin
        count = $urandom_range(1, span + 5);
      end else begin
        count = frame * ((frame <= 40) ? $urandom_range(1, 3) : 1);
      end
      random_sent += count;
      run_phase(cols, rows, pick_weight(), pick_weight(), count);
    end

    if (mismatches == 0) begin
      $display("wave_first_step_stencil_core: match");
    end else begin
      $display("wave_first_step_stencil_core: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/wfs_pkg.sv
rtl/wfs_ram.sv
rtl/wfs_front.sv
rtl/wfs_arith.sv
rtl/wave_first_step_stencil_core.sv
test/stencil_checker.sv
test/tb.sv
